FILE: rtl/core/ccr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccr_pkg
// Shared constants and inter-module structs of the arc-length path core.
// ----------------------------------------------------------------------------
package ccr_pkg;

    localparam int MAX_PTS   = 64;
    localparam int PT_AW     = $clog2(MAX_PTS);
    localparam int CNT_W     = PT_AW + 1;
    localparam int SEG_DEPTH = MAX_PTS - 1;
    localparam int SPS       = 16;
    localparam int SMP_W     = $clog2(SPS);
    localparam int ARC_AW    = PT_AW + SMP_W;
    localparam int ARC_DEPTH = SEG_DEPTH * SPS;
    localparam int T_FRAC    = 16;
    localparam int T_W       = T_FRAC + 1;
    localparam int CO_W      = 40;
    localparam int PROD_W    = CO_W + T_W + 1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FEW     = 2'd1,
        ST_OVF     = 2'd2,
        ST_NOBUILD = 2'd3
    } t_status;

    typedef struct packed {
        logic             en;
        logic [PT_AW-1:0] addr;
        logic [31:0]      x;
        logic [31:0]      y;
        logic [31:0]      z;
    } t_pt_wr;

    typedef struct packed {
        logic             go;
        logic [PT_AW-1:0] seg;
        logic [T_W-1:0]   t;
        logic [CNT_W-1:0] count;
    } t_ev_req;

    typedef struct packed {
        logic        done;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_ev_rsp;

    typedef struct packed {
        logic        go;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic [31:0] bx;
        logic [31:0] by;
        logic [31:0] bz;
    } t_sl_req;

    typedef struct packed {
        logic        done;
        logic [32:0] len;
    } t_sl_rsp;

endpackage
`default_nettype wire

FILE: rtl/core/ccr_eval.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccr_eval
// Waypoint store and Catmull-Rom curve evaluator (Horner, one multiplier).
// ----------------------------------------------------------------------------
module ccr_eval (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ccr_pkg::t_pt_wr  i_wr,
    input  ccr_pkg::t_ev_req i_req,
    output ccr_pkg::t_ev_rsp o_rsp
);
    import ccr_pkg::*;

    typedef enum logic [5:0] {
        E_IDLE  = 6'b000001,
        E_FETCH = 6'b000010,
        E_COEF  = 6'b000100,
        E_MUL   = 6'b001000,
        E_ADD   = 6'b010000,
        E_FIN   = 6'b100000
    } t_estate;

    logic [95:0]             r_pts [MAX_PTS];
    logic [95:0]             r_rd;
    logic [PT_AW-1:0]        rd_addr;
    t_estate                 r_state;
    logic [PT_AW-1:0]        r_seg;
    logic [T_W-1:0]          r_t;
    logic [CNT_W-1:0]        r_cnt;
    logic [2:0]              r_fc;
    logic [2:0]              fcm1;
    logic [95:0]             r_raw [4];
    logic [1:0]              r_axis;
    logic [1:0]              r_step;
    logic signed [CO_W-1:0]  r_ca, r_cb, r_cc, r_acc;
    logic signed [PROD_W-1:0] r_prod;
    logic [31:0]             r_pos [3];
    logic                    r_done;

    logic signed [CO_W-1:0]  p0, p1, p2, p3;
    logic signed [CO_W-1:0]  coef;
    logic signed [PROD_W-1:0] rnd;
    logic signed [CO_W-1:0]  fin;
    logic [31:0]             fin_sat;

    function automatic logic signed [CO_W-1:0] pick(input logic [95:0] w,
                                                    input logic [1:0] ax);
        logic [31:0] v;
        case (ax)
            2'd0:    v = w[95:64];
            2'd1:    v = w[63:32];
            default: v = w[31:0];
        endcase
        return CO_W'($signed(v));
    endfunction

    // point store
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_pts[i_wr.addr] <= {i_wr.x, i_wr.y, i_wr.z};
        end
        r_rd <= r_pts[rd_addr];
    end

    // neighbours seg-1 .. seg+2, one per cycle
    assign rd_addr = r_seg + PT_AW'(r_fc) - PT_AW'(1);
    assign fcm1    = r_fc - 3'd1;

    always_comb begin
        p1 = pick(r_raw[1], r_axis);
        p2 = pick(r_raw[2], r_axis);
        p0 = (r_seg == '0) ? ((p1 <<< 1) - p2) : pick(r_raw[0], r_axis);
        p3 = (({1'b0, r_seg} + CNT_W'(2)) >= r_cnt) ? ((p2 <<< 1) - p1)
                                                     : pick(r_raw[3], r_axis);
        case (r_step)
            2'd0:    coef = r_cc;
            2'd1:    coef = r_cb;
            default: coef = r_ca;
        endcase
        rnd = r_prod + PROD_W'(32768);
        fin = (r_acc + CO_W'(1)) >>> 1;
        if (fin > CO_W'(32'sh7FFFFFFF)) begin
            fin_sat = 32'h7FFFFFFF;
        end else if (fin < -CO_W'(33'sh80000000)) begin
            fin_sat = 32'h80000000;
        end else begin
            fin_sat = fin[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                E_IDLE: begin
                    if (i_req.go) begin
                        r_seg   <= i_req.seg;
                        r_t     <= i_req.t;
                        r_cnt   <= i_req.count;
                        r_fc    <= '0;
                        r_state <= E_FETCH;
                    end
                end
                E_FETCH: begin
                    if (r_fc != '0) begin
                        r_raw[fcm1[1:0]] <= r_rd;
                    end
                    r_fc <= r_fc + 3'd1;
                    if (r_fc == 3'd4) begin
                        r_axis  <= '0;
                        r_state <= E_COEF;
                    end
                end
                E_COEF: begin
                    r_ca    <= p1 <<< 1;
                    r_cb    <= p2 - p0;
                    r_cc    <= (p0 <<< 1) - ((p1 <<< 2) + p1) + (p2 <<< 2) - p3;
                    r_acc   <= p3 - p0 + ((p1 <<< 1) + p1) - ((p2 <<< 1) + p2);
                    r_step  <= '0;
                    r_state <= E_MUL;
                end
                E_MUL: begin
                    r_prod  <= r_acc * $signed({1'b0, r_t});
                    r_state <= E_ADD;
                end
                E_ADD: begin
                    r_acc  <= $signed(rnd[CO_W+15:16]) + coef;
                    r_step <= r_step + 2'd1;
                    r_state <= (r_step == 2'd2) ? E_FIN : E_MUL;
                end
                E_FIN: begin
                    r_pos[r_axis] <= fin_sat;
                    if (r_axis == 2'd2) begin
                        r_done  <= 1'b1;
                        r_state <= E_IDLE;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= E_COEF;
                    end
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.x    = r_pos[0];
    assign o_rsp.y    = r_pos[1];
    assign o_rsp.z    = r_pos[2];

endmodule
`default_nettype wire

FILE: rtl/core/ccr_steplen.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccr_steplen
// Straight-line distance between two points: squares and bit-serial root.
// ----------------------------------------------------------------------------
module ccr_steplen (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ccr_pkg::t_sl_req i_req,
    output ccr_pkg::t_sl_rsp o_rsp
);
    import ccr_pkg::*;

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_PREP = 4'b0010,
        L_SQ   = 4'b0100,
        L_ROOT = 4'b1000
    } t_lstate;

    t_lstate     r_state;
    logic [32:0] r_dd [3];
    logic [30:0] r_ds [3];
    logic        r_sh;
    logic [1:0]  r_k;
    logic [61:0] r_sq;
    logic [63:0] r_sum;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic        r_done;
    logic [32:0] r_len;

    logic        sh;
    logic [63:0] trial;
    logic        take;
    logic [63:0] res_n;

    function automatic logic [32:0] absd(input logic [31:0] a, input logic [31:0] b);
        logic signed [33:0] df;
        logic signed [33:0] ng;
        df = $signed({a[31], a[31], a}) - $signed({b[31], b[31], b});
        ng = -df;
        return df[33] ? ng[32:0] : df[32:0];
    endfunction

    assign sh    = r_dd[0][32] | r_dd[0][31] | r_dd[1][32] | r_dd[1][31]
                 | r_dd[2][32] | r_dd[2][31];
    assign trial = r_res + r_bit;
    assign take  = r_sum >= trial;
    assign res_n = take ? ((r_res >> 1) + r_bit) : (r_res >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                L_IDLE: begin
                    if (i_req.go) begin
                        r_dd[0] <= absd(i_req.ax, i_req.bx);
                        r_dd[1] <= absd(i_req.ay, i_req.by);
                        r_dd[2] <= absd(i_req.az, i_req.bz);
                        r_state <= L_PREP;
                    end
                end
                L_PREP: begin
                    // halve all three when any difference reaches 2^31
                    for (int i = 0; i < 3; i++) begin
                        r_ds[i] <= sh ? r_dd[i][31:1] : r_dd[i][30:0];
                    end
                    r_sh    <= sh;
                    r_sum   <= '0;
                    r_k     <= '0;
                    r_state <= L_SQ;
                end
                L_SQ: begin
                    if (r_k != 2'd3) begin
                        r_sq <= 62'(r_ds[r_k] * r_ds[r_k]);
                    end
                    if (r_k != 2'd0) begin
                        r_sum <= r_sum + {2'b00, r_sq};
                    end
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_res   <= '0;
                        r_bit   <= 64'h4000_0000_0000_0000;
                        r_state <= L_ROOT;
                    end
                end
                L_ROOT: begin
                    if (take) begin
                        r_sum <= r_sum - trial;
                    end
                    r_res <= res_n;
                    r_bit <= r_bit >> 2;
                    if (r_bit == 64'd1) begin
                        r_len   <= r_sh ? {res_n[31:0], 1'b0} : {1'b0, res_n[31:0]};
                        r_done  <= 1'b1;
                        r_state <= L_IDLE;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.len  = r_len;

endmodule
`default_nettype wire

FILE: rtl/core/catmull_rom_arc_length_path_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// catmull_rom_arc_length_path_core
// Arc-length lookup along a uniform Catmull-Rom path through 3D waypoints.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. kind 0 loads a
// waypoint; the one flagged last_point builds the arc-length tables. kind 1
// is a distance query. Results appear on the o_ ports for one cycle with
// o_done high; the receiver cannot hold them off.
// A load that is not last gives no result and leaves busy low.
// An error result (too few points, store overflow, query before a build)
// appears in the cycle after the transaction is taken.
// The build evaluates every sample of every segment through one shared
// curve unit and one root unit.
// A query scans the segment-end table one segment at a time, then runs the
// sample search, a 16-step divide and the curve evaluation.
// busy stays high until the result has been issued. Reset clears the point
// count and the built flag; table contents are then meaningless until the
// next build writes them.
// ----------------------------------------------------------------------------
module catmull_rom_arc_length_path_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_kind,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic               i_last_point,
    input  logic [31:0]        i_query_distance,
    output logic               o_done,
    output logic [31:0]        o_total_length,
    output logic [5:0]         o_segment_index,
    output logic [15:0]        o_segment_t,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic [1:0]         o_status
);
    import ccr_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE      = 19'h00001,
        S_B_ORG     = 19'h00002,
        S_B_ORG_W   = 19'h00004,
        S_B_SMP     = 19'h00008,
        S_B_SMP_W   = 19'h00010,
        S_B_LEN     = 19'h00020,
        S_B_LEN_W   = 19'h00040,
        S_Q_SCAN    = 19'h00080,
        S_Q_SCAN_CK = 19'h00100,
        S_Q_LEN     = 19'h00200,
        S_Q_LEN_CK  = 19'h00400,
        S_Q_BS      = 19'h00800,
        S_Q_BS_CK   = 19'h01000,
        S_Q_CUR     = 19'h02000,
        S_Q_PRV     = 19'h04000,
        S_Q_PRV_CK  = 19'h08000,
        S_Q_DIV     = 19'h10000,
        S_Q_EV      = 19'h20000,
        S_Q_EV_W    = 19'h40000
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic              r_built;
    logic              r_lost;
    logic [31:0]       r_path_len;
    logic [PT_AW-1:0]  r_seg;
    logic [SMP_W-1:0]  r_s;
    logic [31:0]       r_cum;
    logic [31:0]       r_total;
    logic [31:0]       r_prev [3];
    logic [31:0]       r_curp [3];
    logic [31:0]       r_dist;
    logic [PT_AW-1:0]  r_idx;
    logic [31:0]       r_prev_end;
    logic [31:0]       r_dis;
    logic [SMP_W-1:0]  r_lo, r_hi;
    logic [31:0]       r_cur;
    logic [31:0]       r_rem;
    logic [31:0]       r_den;
    logic [T_W-1:0]    r_q;
    logic [SMP_W-1:0]  r_dc;
    logic [T_W-1:0]    r_t;

    logic [31:0]       r_arc_mem [ARC_DEPTH];
    logic [31:0]       r_arc_q;
    logic [31:0]       r_end_mem [SEG_DEPTH];
    logic [31:0]       r_end_q;

    logic              r_done;
    logic [31:0]       r_o_total;
    logic [5:0]        r_o_seg;
    logic [15:0]       r_o_t;
    logic [31:0]       r_o_x, r_o_y, r_o_z;
    logic [1:0]        r_o_status;

    t_pt_wr            pt_wr;
    t_ev_req           ev_req;
    t_ev_rsp           ev_rsp;
    t_sl_req           sl_req;
    t_sl_rsp           sl_rsp;

    logic              accept;
    logic [CNT_W-1:0]  cnt_base;
    logic [CNT_W-1:0]  cnt_new;
    logic              lost_new;
    logic              room;
    logic [ARC_AW-1:0] arc_raddr;
    logic              arc_we;
    logic [31:0]       cum_n;
    logic [31:0]       tot_n;
    logic [SMP_W:0]    mid_sum;
    logic [SMP_W-1:0]  mid;
    logic [SMP_W-1:0]  lo_n, hi_n;
    logic [PT_AW-1:0]  last_seg;
    logic [31:0]       prev_v;
    logic [31:0]       num0;
    logic              ge0;
    logic [32:0]       rem2;
    logic              ge;
    logic [T_W+SMP_W-1:0] t_sum;
    logic [T_W+SMP_W-1:0] t_shf;
    logic [T_W-1:0]    t_q;
    logic [T_W-1:0]    smp_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [32:0] b);
        logic [33:0] s;
        s = {2'b00, a} + {1'b0, b};
        return (s > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // load bookkeeping
    // ------------------------------------------------------------------
    assign cnt_base = r_built ? '0 : r_count;
    assign room     = cnt_base < CNT_W'(MAX_PTS);
    assign cnt_new  = room ? (cnt_base + CNT_W'(1)) : cnt_base;
    assign lost_new = room ? (r_built ? 1'b0 : r_lost) : 1'b1;

    assign pt_wr.en   = accept && !i_kind && room;
    assign pt_wr.addr = cnt_base[PT_AW-1:0];
    assign pt_wr.x    = i_point_x;
    assign pt_wr.y    = i_point_y;
    assign pt_wr.z    = i_point_z;

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    assign last_seg = PT_AW'(r_count - CNT_W'(2));
    assign smp_t    = {({1'b0, r_s} + (SMP_W+1)'(1)), {(T_FRAC-SMP_W){1'b0}}};
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = mid_sum[SMP_W:1];
    assign lo_n     = (r_arc_q < r_dis) ? (mid + SMP_W'(1)) : r_lo;
    assign hi_n     = (r_arc_q < r_dis) ? r_hi : mid;
    assign cum_n    = sat_add(r_cum, sl_rsp.len);
    assign tot_n    = sat_add(r_total, {1'b0, cum_n});
    assign prev_v   = (r_lo == '0) ? 32'd0 : r_arc_q;
    assign num0     = r_dis - prev_v;
    assign ge0      = num0 >= (r_cur - prev_v);
    assign rem2     = {r_rem, 1'b0};
    assign ge       = rem2 >= {1'b0, r_den};
    assign t_sum    = {1'b0, r_lo, {T_FRAC{1'b0}}} + (T_W+SMP_W)'(r_q);
    assign t_shf    = t_sum >> SMP_W;
    assign t_q      = t_shf[T_W-1:0];

    always_comb begin
        case (r_state)
            S_Q_LEN: arc_raddr = {r_seg, {SMP_W{1'b1}}};
            S_Q_BS:  arc_raddr = {r_seg, mid};
            S_Q_CUR: arc_raddr = {r_seg, r_lo};
            S_Q_PRV: arc_raddr = {r_seg, r_lo - SMP_W'(1)};
            default: arc_raddr = {r_seg, r_s};
        endcase
    end

    assign arc_we = (r_state == S_B_LEN_W) && sl_rsp.done;

    // ------------------------------------------------------------------
    // tables
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (arc_we) begin
            r_arc_mem[{r_seg, r_s}] <= cum_n;
        end
        r_arc_q <= r_arc_mem[arc_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (arc_we && (r_s == {SMP_W{1'b1}})) begin
            r_end_mem[r_seg] <= tot_n;
        end
        r_end_q <= r_end_mem[r_idx];
    end

    // ------------------------------------------------------------------
    // shared units
    // ------------------------------------------------------------------
    always_comb begin
        ev_req.go    = (r_state == S_B_ORG) || (r_state == S_B_SMP) || (r_state == S_Q_EV);
        ev_req.seg   = r_seg;
        ev_req.count = r_count;
        case (r_state)
            S_B_SMP: ev_req.t = smp_t;
            S_Q_EV:  ev_req.t = t_q;
            default: ev_req.t = '0;
        endcase
    end

    assign sl_req.go = (r_state == S_B_LEN);
    assign sl_req.ax = r_prev[0];
    assign sl_req.ay = r_prev[1];
    assign sl_req.az = r_prev[2];
    assign sl_req.bx = r_curp[0];
    assign sl_req.by = r_curp[1];
    assign sl_req.bz = r_curp[2];

    ccr_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (pt_wr),
        .i_req   (ev_req),
        .o_rsp   (ev_rsp)
    );

    ccr_steplen u_steplen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sl_req),
        .o_rsp   (sl_rsp)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_built    <= 1'b0;
            r_lost     <= 1'b0;
            r_path_len <= '0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_o_total  <= '0;
                        r_o_seg    <= '0;
                        r_o_t      <= '0;
                        r_o_x      <= '0;
                        r_o_y      <= '0;
                        r_o_z      <= '0;
                        if (!i_kind) begin
                            r_built <= 1'b0;
                            r_count <= cnt_new;
                            r_lost  <= lost_new;
                            if (i_last_point) begin
                                if (lost_new) begin
                                    r_count    <= '0;
                                    r_lost     <= 1'b0;
                                    r_o_status <= ST_OVF;
                                    r_done     <= 1'b1;
                                end else if (cnt_new < CNT_W'(2)) begin
                                    r_count    <= '0;
                                    r_lost     <= 1'b0;
                                    r_o_status <= ST_FEW;
                                    r_done     <= 1'b1;
                                end else begin
                                    r_seg   <= '0;
                                    r_total <= '0;
                                    r_state <= S_B_ORG;
                                end
                            end
                        end else if (!r_built) begin
                            r_o_status <= ST_NOBUILD;
                            r_done     <= 1'b1;
                        end else begin
                            r_dist     <= (i_query_distance > r_path_len) ? r_path_len
                                                                          : i_query_distance;
                            r_idx      <= '0;
                            r_prev_end <= '0;
                            r_state    <= S_Q_SCAN;
                        end
                    end
                end

                // build: origin of the segment, then each sample
                S_B_ORG: r_state <= S_B_ORG_W;
                S_B_ORG_W: begin
                    if (ev_rsp.done) begin
                        r_prev[0] <= ev_rsp.x;
                        r_prev[1] <= ev_rsp.y;
                        r_prev[2] <= ev_rsp.z;
                        r_s       <= '0;
                        r_cum     <= '0;
                        r_state   <= S_B_SMP;
                    end
                end
                S_B_SMP: r_state <= S_B_SMP_W;
                S_B_SMP_W: begin
                    if (ev_rsp.done) begin
                        r_curp[0] <= ev_rsp.x;
                        r_curp[1] <= ev_rsp.y;
                        r_curp[2] <= ev_rsp.z;
                        r_state   <= S_B_LEN;
                    end
                end
                S_B_LEN: r_state <= S_B_LEN_W;
                S_B_LEN_W: begin
                    if (sl_rsp.done) begin
                        r_cum  <= cum_n;
                        r_prev <= r_curp;
                        r_s    <= r_s + SMP_W'(1);
                        if (r_s == {SMP_W{1'b1}}) begin
                            r_total <= tot_n;
                            if (r_seg == last_seg) begin
                                r_path_len <= tot_n;
                                r_built    <= 1'b1;
                                r_o_total  <= tot_n;
                                r_o_status <= ST_OK;
                                r_done     <= 1'b1;
                                r_state    <= S_IDLE;
                            end else begin
                                r_seg   <= r_seg + PT_AW'(1);
                                r_state <= S_B_ORG;
                            end
                        end else begin
                            r_state <= S_B_SMP;
                        end
                    end
                end

                // query: linear scan of segment ends
                S_Q_SCAN: r_state <= S_Q_SCAN_CK;
                S_Q_SCAN_CK: begin
                    if ((r_dist <= r_end_q) || (r_idx == last_seg)) begin
                        r_seg   <= r_idx;
                        r_dis   <= (r_dist > r_prev_end) ? (r_dist - r_prev_end) : 32'd0;
                        r_state <= S_Q_LEN;
                    end else begin
                        r_prev_end <= r_end_q;
                        r_idx      <= r_idx + PT_AW'(1);
                        r_state    <= S_Q_SCAN;
                    end
                end
                S_Q_LEN: r_state <= S_Q_LEN_CK;
                S_Q_LEN_CK: begin
                    r_lo <= '0;
                    r_hi <= {SMP_W{1'b1}};
                    if (r_arc_q == '0) begin
                        r_q     <= '0;
                        r_state <= S_Q_EV;
                    end else begin
                        if (r_dis > r_arc_q) begin
                            r_dis <= r_arc_q;
                        end
                        r_state <= S_Q_BS;
                    end
                end

                // binary search for the first sample at or past the distance
                S_Q_BS: r_state <= S_Q_BS_CK;
                S_Q_BS_CK: begin
                    r_lo    <= lo_n;
                    r_hi    <= hi_n;
                    r_state <= (lo_n < hi_n) ? S_Q_BS : S_Q_CUR;
                end
                S_Q_CUR: r_state <= S_Q_PRV;
                S_Q_PRV: begin
                    r_cur   <= r_arc_q;
                    r_state <= S_Q_PRV_CK;
                end
                S_Q_PRV_CK: begin
                    if ((r_cur > prev_v) && (r_dis > prev_v)) begin
                        r_den   <= r_cur - prev_v;
                        r_rem   <= ge0 ? (num0 - (r_cur - prev_v)) : num0;
                        r_q     <= T_W'(ge0);
                        r_dc    <= '0;
                        r_state <= S_Q_DIV;
                    end else begin
                        r_q     <= '0;
                        r_state <= S_Q_EV;
                    end
                end

                // restoring divide, one quotient bit per cycle
                S_Q_DIV: begin
                    r_rem <= ge ? 32'(rem2 - {1'b0, r_den}) : rem2[31:0];
                    r_q   <= {r_q[T_W-2:0], ge};
                    r_dc  <= r_dc + SMP_W'(1);
                    if (r_dc == {SMP_W{1'b1}}) begin
                        r_state <= S_Q_EV;
                    end
                end
                S_Q_EV: begin
                    r_t     <= t_q;
                    r_state <= S_Q_EV_W;
                end
                S_Q_EV_W: begin
                    if (ev_rsp.done) begin
                        r_o_total  <= r_path_len;
                        r_o_seg    <= r_seg;
                        r_o_t      <= r_t[T_W-1] ? 16'hFFFF : r_t[15:0];
                        r_o_x      <= ev_rsp.x;
                        r_o_y      <= ev_rsp.y;
                        r_o_z      <= ev_rsp.z;
                        r_o_status <= ST_OK;
                        r_done     <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done          = r_done;
    assign o_total_length  = r_o_total;
    assign o_segment_index = r_o_seg;
    assign o_segment_t     = r_o_t;
    assign o_pos_x         = r_o_x;
    assign o_pos_y         = r_o_y;
    assign o_pos_z         = r_o_z;
    assign o_status        = r_o_status;

endmodule
`default_nettype wire

FILE: tb/catmull_rom_arc_length_path_core_tb.sv
// ----------------------------------------------------------------------------
// catmull_rom_arc_length_path_core_tb
// Self-checking bench for the arc-length path core: waypoint loads, table
// builds and distance queries are predicted in the bench and every result
// strobe is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module catmull_rom_arc_length_path_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ccr_pkg::*;

    localparam int  NPTS       = 64;
    localparam int  NSMP       = 16;
    localparam int  RAND_ITEMS = 1450;
    localparam longint CYCLE_LIMIT = 5000000;
    localparam bit  KIND_LOAD  = 1'b0;
    localparam bit  KIND_QUERY = 1'b1;

    typedef struct {
        logic [31:0] total;
        logic [5:0]  seg;
        logic [15:0] t;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        t_status     status;
    } path_result_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_kind = 1'b0;
    logic signed [31:0] i_point_x = '0;
    logic signed [31:0] i_point_y = '0;
    logic signed [31:0] i_point_z = '0;
    logic               i_last_point = 1'b0;
    logic [31:0]        i_query_distance = '0;
    logic               o_done;
    logic [31:0]        o_total_length;
    logic [5:0]         o_segment_index;
    logic [15:0]        o_segment_t;
    logic signed [31:0] o_pos_x;
    logic signed [31:0] o_pos_y;
    logic signed [31:0] o_pos_z;
    logic [1:0]         o_status;

    catmull_rom_arc_length_path_core uut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    longint      wp[3][NPTS];
    logic [31:0] arc_cum[NPTS * NSMP];
    logic [31:0] seg_end[NPTS];
    logic [31:0] path_len;
    int          pt_count;
    bit          built;
    bit          lost;

    path_result_t expected_q[$];
    int     fails = 0;
    int     items_sent = 0;
    int     n_loads = 0, n_queries = 0, n_builds = 0, n_errors = 0, n_checked = 0;
    int     burst_left = 0;
    longint cycles = 0;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint curve_axis(int ax, int seg, int t);
        longint p0, p1, p2, p3, a, b, c, d, acc, tt;
        p1 = wp[ax][seg];
        p2 = wp[ax][seg + 1];
        p0 = (seg == 0) ? 2 * p1 - p2 : wp[ax][seg - 1];
        p3 = (seg + 2 >= pt_count) ? 2 * p2 - p1 : wp[ax][seg + 2];
        a  = 2 * p1;
        b  = p2 - p0;
        c  = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        d  = -p0 + 3 * p1 - 3 * p2 + p3;
        tt = t;
        acc = d;
        acc = ((acc * tt + 32768) >>> 16) + c;
        acc = ((acc * tt + 32768) >>> 16) + b;
        acc = ((acc * tt + 32768) >>> 16) + a;
        return sat32((acc + 1) >>> 1);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res, bt;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] chord_length(longint pa[3], longint pb[3]);
        logic [63:0] dd[3];
        logic [63:0] sum;
        int sh;
        for (int k = 0; k < 3; k++)
            dd[k] = (pa[k] > pb[k]) ? pa[k] - pb[k] : pb[k] - pa[k];
        sh = ((dd[0] | dd[1] | dd[2]) >= (64'd1 << 31)) ? 1 : 0;
        sum = 0;
        for (int k = 0; k < 3; k++) begin
            dd[k] = dd[k] >> sh;
            sum += dd[k] * dd[k];
        end
        return int_sqrt(sum) << sh;
    endfunction

    function automatic void build_tables();
        logic [63:0] total, cum;
        longint pv[3], cv[3];
        int t;
        total = 0;
        for (int seg = 0; seg + 1 < pt_count; seg++) begin
            cum = 0;
            for (int k = 0; k < 3; k++) pv[k] = curve_axis(k, seg, 0);
            for (int s = 0; s < NSMP; s++) begin
                t = ((s + 1) * 65536) / NSMP;
                for (int k = 0; k < 3; k++) cv[k] = curve_axis(k, seg, t);
                cum += chord_length(pv, cv);
                if (cum > 64'hFFFF_FFFF) cum = 64'hFFFF_FFFF;
                arc_cum[seg * NSMP + s] = cum[31:0];
                pv = cv;
            end
            total += cum;
            if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
            seg_end[seg] = total[31:0];
        end
        path_len = total[31:0];
    endfunction

    function automatic void drop_path();
        pt_count = 0;
        built    = 0;
        lost     = 0;
    endfunction

    // returns 1 when the transaction produces a result
    function automatic bit predict_path(input bit kind, input logic [31:0] px, py, pz,
                                        input bit last, input logic [31:0] qd,
                                        output path_result_t r);
        logic [63:0] d, st, dis, slen, prv, cur, frac, t;
        int nseg, seg, lo, hi, mid, base;
        r = '{total: 0, seg: 0, t: 0, x: 0, y: 0, z: 0, status: ST_OK};
        if (kind == KIND_LOAD) begin
            if (built) drop_path();
            if (pt_count < NPTS) begin
                wp[0][pt_count] = longint'(signed'(px));
                wp[1][pt_count] = longint'(signed'(py));
                wp[2][pt_count] = longint'(signed'(pz));
                pt_count++;
            end else begin
                lost = 1;
            end
            if (!last) return 0;
            if (lost) begin
                drop_path();
                r.status = ST_OVF;
                return 1;
            end
            if (pt_count < 2) begin
                drop_path();
                r.status = ST_FEW;
                return 1;
            end
            build_tables();
            built   = 1;
            r.total = path_len;
            return 1;
        end
        if (!built) begin
            r.status = ST_NOBUILD;
            return 1;
        end
        d = 64'(qd);
        if (d > 64'(path_len)) d = 64'(path_len);
        nseg = pt_count - 1;
        seg  = nseg - 1;
        for (int i = 0; i < nseg; i++) begin
            if (d <= 64'(seg_end[i])) begin
                seg = i;
                break;
            end
        end
        st   = (seg > 0) ? 64'(seg_end[seg - 1]) : 64'd0;
        dis  = (d > st) ? d - st : 64'd0;
        base = seg * NSMP;
        slen = 64'(arc_cum[base + NSMP - 1]);
        t = 0;
        if (slen != 0) begin
            if (dis > slen) dis = slen;
            lo = 0;
            hi = NSMP - 1;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (64'(arc_cum[base + mid]) < dis) lo = mid + 1;
                else hi = mid;
            end
            prv  = (lo == 0) ? 64'd0 : 64'(arc_cum[base + lo - 1]);
            cur  = 64'(arc_cum[base + lo]);
            frac = (cur > prv && dis > prv) ? ((dis - prv) * 65536) / (cur - prv) : 64'd0;
            t    = (64'(lo) * 65536 + frac) / NSMP;
            if (t > 65536) t = 65536;
        end
        r.total = path_len;
        r.seg   = seg[5:0];
        r.t     = (t > 65535) ? 16'hFFFF : t[15:0];
        r.x     = 32'(curve_axis(0, seg, int'(t)));
        r.y     = 32'(curve_axis(1, seg, int'(t)));
        r.z     = 32'(curve_axis(2, seg, int'(t)));
        return 1;
    endfunction

    // result checker: the receiver never stalls, every strobe is a transaction
    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        path_result_t e;
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d",
                         $time, o_status);
                fails++;
            end else begin
                e = expected_q.pop_front();
                n_checked++;
                check_field("total_length", e.total, o_total_length);
                check_field("segment_index", 32'(e.seg), 32'(o_segment_index));
                check_field("segment_t", 32'(e.t), 32'(o_segment_t));
                check_field("pos_x", e.x, o_pos_x);
                check_field("pos_y", e.y, o_pos_y);
                check_field("pos_z", e.z, o_pos_z);
                check_field("status", 32'(e.status), 32'(o_status));
            end
        end
    end

    // called just after a rising edge; leaves start high on return
    task automatic send_item(bit kind, logic [31:0] px, py, pz, bit last, logic [31:0] qd);
        path_result_t r;
        int           gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(4, 0) == 0) ? $urandom_range(12, 1) : $urandom_range(2, 0);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 10)
                                                      : $urandom_range(4, 1);
        end
        burst_left--;
        start            <= 1'b1;
        i_kind           <= kind;
        i_point_x        <= px;
        i_point_y        <= py;
        i_point_z        <= pz;
        i_last_point     <= last;
        i_query_distance <= qd;
        do @(posedge i_clk); while (busy !== 1'b0);
        items_sent++;
        if (kind == KIND_LOAD) n_loads++;
        else n_queries++;
        if (predict_path(kind, px, py, pz, last, qd, r)) begin
            expected_q.push_back(r);
            if (r.status == ST_OK && kind == KIND_LOAD) n_builds++;
            if (r.status != ST_OK) n_errors++;
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0) @(posedge i_clk);
        // a non-last load may still be finishing
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(7, 0))
            0:       return $urandom();
            1:       return $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(2 << 20, 0)) - (1 << 20));
        endcase
    endfunction

    function automatic logic [31:0] rand_distance();
        logic [63:0] span;
        span = 64'(path_len) + (path_len >> 3) + 1;
        case ($urandom_range(9, 0))
            0:       return $urandom();
            1:       return 0;
            2:       return 32'hFFFF_FFFF;
            3:       return path_len;
            default: return (span > 64'hFFFF_FFFF) ? $urandom()
                                                   : 32'(64'($urandom()) % span);
        endcase
    endfunction

    task automatic load_path(int n);
        for (int i = 0; i < n; i++)
            send_item(KIND_LOAD, rand_coord(), rand_coord(), rand_coord(), i == n - 1, 0);
    endtask

    task automatic test_directed();
        send_item(KIND_QUERY, 0, 0, 0, 0, 32'h100);
        send_item(KIND_LOAD, 32'h100, 32'h200, 32'h300, 1, 0);
        // extreme coordinates force saturation on positions and lengths
        send_item(KIND_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        send_item(KIND_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
        send_item(KIND_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0);
        send_item(KIND_QUERY, 0, 0, 0, 0, 32'h0);
        send_item(KIND_QUERY, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_item(KIND_QUERY, 0, 0, 0, 0, 32'h8000_0000);
        // new path after a build; query while it is still loading
        send_item(KIND_LOAD, 32'h0, 32'h0, 32'h0, 0, 0);
        send_item(KIND_QUERY, 0, 0, 0, 0, 32'h10);
        send_item(KIND_LOAD, 32'h1000, 32'hFFFF_F000, 32'h0800, 0, 0);
        send_item(KIND_LOAD, 32'h3000, 32'h0000_2000, 32'hFFFF_0000, 1, 0);
        send_item(KIND_QUERY, 0, 0, 0, 0, 32'h0);
        send_item(KIND_QUERY, 0, 0, 0, 0, 32'h1000);
        send_item(KIND_QUERY, 0, 0, 0, 0, 32'hFFFF_FFFF);
        // zero-length path: every segment and interval is empty
        send_item(KIND_LOAD, 32'h500, 32'h500, 32'h500, 0, 0);
        send_item(KIND_LOAD, 32'h500, 32'h500, 32'h500, 0, 0);
        send_item(KIND_LOAD, 32'h500, 32'h500, 32'h500, 1, 0);
        send_item(KIND_QUERY, 0, 0, 0, 0, 32'h0);
        send_item(KIND_QUERY, 0, 0, 0, 0, 32'h1234);
        drain();
    endtask

    task automatic test_store_overflow();
        for (int i = 0; i < NPTS + 2; i++)
            send_item(KIND_LOAD, rand_coord(), rand_coord(), rand_coord(), i == NPTS + 1, 0);
        send_item(KIND_QUERY, 0, 0, 0, 0, 32'h0);
        drain();
    endtask

    task automatic test_full_store();
        load_path(NPTS);
        for (int i = 0; i < 12; i++)
            send_item(KIND_QUERY, 0, 0, 0, 0, rand_distance());
        send_item(KIND_QUERY, 0, 0, 0, 0, path_len);
        drain();
    endtask

    task automatic test_random();
        int n;
        while (items_sent < RAND_ITEMS) begin
            if ($urandom_range(7, 0) == 0) drain();
            case ($urandom_range(19, 0))
                0: send_item(KIND_QUERY, 0, 0, 0, 0, $urandom());
                1: send_item(KIND_LOAD, rand_coord(), rand_coord(), rand_coord(), 1, 0);
                default: begin
                    n = ($urandom_range(39, 0) == 0) ? $urandom_range(24, 8)
                                                     : $urandom_range(6, 2);
                    load_path(n);
                    repeat ($urandom_range(16, 3))
                        send_item(KIND_QUERY, 0, 0, 0, 0, rand_distance());
                end
            endcase
        end
        drain();
    endtask

    initial begin
        drop_path();
        path_len = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_store_overflow();
        test_full_store();
        test_random();
        repeat (200) @(posedge i_clk);
        $display("covered %0d loads, %0d queries, %0d builds, %0d error results",
                 n_loads, n_queries, n_builds, n_errors);
        $display("%0d results compared in %0d cycles", n_checked, cycles);
        if (fails == 0 && expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results outstanding", fails, expected_q.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
